// File: sv/i2c_fts_pkg.sv
// ----------------------------------------------------------------------------
// I2C FIFO transfer sequencer package
// Shared sizes, command and mask bits, and the opcode, kind and status codes.
// ----------------------------------------------------------------------------
package i2c_fts_pkg;

  // Controller FIFO depth and largest transfer length
  localparam int FIFO_DEPTH = 32;
  localparam int MAX_LEN    = 256;

  // Pops plus pushes per status transaction
  localparam int RESULT_BUDGET = 34;

  localparam int LEN_W   = 9;                          // byte counts
  localparam int LVL_W   = 6;                          // FIFO levels as reported
  localparam int PTR_W   = $clog2(MAX_LEN);            // transmit buffer index
  localparam int ROOM_W  = $clog2(FIFO_DEPTH + 1);     // free space, outstanding reads
  localparam int BUD_W   = $clog2(RESULT_BUDGET + 1);  // result budget
  localparam int CMD_W   = 10;
  localparam int TGT_W   = 17;
  localparam int MASK_W  = 13;
  localparam int STAT_W  = 2;
  localparam int KIND_W  = 3;
  localparam int OP_W    = 2;

  // Command word bits
  localparam logic [CMD_W-1:0] CMD_READ = 10'h100;
  localparam logic [CMD_W-1:0] CMD_STOP = 10'h200;

  // Target register bits
  localparam logic [TGT_W-1:0] TGT_SPECIAL = 17'h00800;
  localparam logic [TGT_W-1:0] TGT_QUICK   = 17'h10000;

  // Interrupt masks: rx full, tx empty, abort, stop
  localparam logic [MASK_W-1:0] MASK_ALL  = 13'h254;
  localparam logic [MASK_W-1:0] MASK_TXE  = 13'h010;
  localparam logic [MASK_W-1:0] MASK_NONE = 13'h000;

  // Input opcodes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd2;
  localparam logic [OP_W-1:0] OP_RXBYTE = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RXBYTE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MASK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SETUP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd5;

  // Final status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABORT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd2;

endpackage

// File: sv/i2c_fifo_transfer_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C FIFO transfer sequencer
// Drives one master transfer through a controller with command and receive
// FIFOs: target setup, receive pops, command pushes, mask updates, finish.
// ----------------------------------------------------------------------------
// Works on one input transaction at a time. A load transaction, and a status
// transaction while no transfer is active, give no result. Every other
// transaction gives its results at one per cycle through the output register
// while the output does not stall, apart from pop and push states that pass on
// with nothing to give; a status transaction gives at most 34 pops and pushes,
// a quick command, a mask update and a finish. The next transaction is taken
// as soon as the last result sits in the output register. Transmit bytes live
// in a 256 x 8 synchronous RAM read ahead at the next transmit pointer, so
// pushes of write data keep the one-per-cycle pace; reading a buffer entry
// never loaded gives any value.
// ----------------------------------------------------------------------------
module i2c_fifo_transfer_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // is_read, target_addr[7], count[9], data_byte[8], flag_abort, flag_rx_full,
  // flag_tx_empty, flag_stop, tx_level[6], rx_level[6], timed_out, zero pad
  input  logic [47:0] s_tdata,
  // opcode[2]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cmd_word[10], target_word[17], irq_mask[13], rx_data[8], final_status[2],
  // done_count[9], zero pad
  output logic [63:0] m_tdata,
  // kind[3]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  localparam int LEN_W  = i2c_fts_pkg::LEN_W;
  localparam int LVL_W  = i2c_fts_pkg::LVL_W;
  localparam int PTR_W  = i2c_fts_pkg::PTR_W;
  localparam int ROOM_W = i2c_fts_pkg::ROOM_W;
  localparam int BUD_W  = i2c_fts_pkg::BUD_W;

  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(i2c_fts_pkg::MAX_LEN);
  localparam logic [LEN_W-1:0]  LEN_BUD   = LEN_W'(i2c_fts_pkg::RESULT_BUDGET);
  localparam logic [BUD_W-1:0]  BUD_FULL  = BUD_W'(i2c_fts_pkg::RESULT_BUDGET);
  localparam logic [ROOM_W-1:0] DEPTH_R   = ROOM_W'(i2c_fts_pkg::FIFO_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SETUP = 10'b0000000010,
    S_SMASK = 10'b0000000100,
    S_RXB   = 10'b0000001000,
    S_AMASK = 10'b0000010000,
    S_POP   = 10'b0000100000,
    S_QUICK = 10'b0001000000,
    S_PUSH  = 10'b0010000000,
    S_MASK  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  // Input fields
  logic                         in_is_read;
  logic [6:0]                   in_addr;
  logic [LEN_W-1:0]             in_count;
  logic [7:0]                   in_byte;
  logic                         in_abort, in_rx_full, in_tx_empty, in_stop, in_timeout;
  logic [LVL_W-1:0]             in_tx_level, in_rx_level;

  assign in_is_read  = s_tdata[0];
  assign in_addr     = s_tdata[7:1];
  assign in_count    = s_tdata[16:8];
  assign in_byte     = s_tdata[24:17];
  assign in_abort    = s_tdata[25];
  assign in_rx_full  = s_tdata[26];
  assign in_tx_empty = s_tdata[27];
  assign in_stop     = s_tdata[28];
  assign in_tx_level = s_tdata[34:29];
  assign in_rx_level = s_tdata[40:35];
  assign in_timeout  = s_tdata[41];

  // Control and transfer state
  state_t            state, state_next;
  logic              active, active_next;
  logic              reading, reading_next;
  logic [LEN_W-1:0]  total_len, total_len_next;
  logic [LEN_W-1:0]  tx_remaining, tx_remaining_next;
  logic [LEN_W-1:0]  rx_remaining, rx_remaining_next;
  logic [ROOM_W-1:0] rx_outstanding, rx_outstanding_next;
  logic [PTR_W-1:0]  tx_pointer, tx_pointer_next;

  // Per-transaction work registers
  logic [BUD_W-1:0]  pops_left, pops_left_next;
  logic [ROOM_W-1:0] tx_room, tx_room_next;
  logic [ROOM_W-1:0] rx_room, rx_room_next;
  logic [BUD_W-1:0]  budget, budget_next;
  logic [1:0]        fin_status, fin_status_next;
  logic              tx_empty_q, tx_empty_q_next;
  logic              stop_q, stop_q_next;
  logic [16:0]       target_q;
  logic [7:0]        rx_byte_q;

  // Transmit buffer
  logic [7:0]        tx_buffer [i2c_fts_pkg::MAX_LEN];
  logic [7:0]        buf_rd;

  // Output register
  logic              emit, emit_last;
  logic [2:0]        emit_kind;
  logic [9:0]        emit_cmd;
  logic [16:0]       emit_target;
  logic [12:0]       emit_mask;
  logic [7:0]        emit_rx;
  logic [1:0]        emit_status;
  logic [LEN_W-1:0]  emit_count;
  logic [2:0]        out_kind;
  logic [9:0]        out_cmd;
  logic [16:0]       out_target;
  logic [12:0]       out_mask;
  logic [7:0]        out_rx;
  logic [1:0]        out_status;
  logic [LEN_W-1:0]  out_count;

  logic              in_accept, out_free;
  logic [LEN_W-1:0]  cnt_sat, rx_min;
  logic [BUD_W-1:0]  pops_calc;
  logic [LVL_W-1:0]  rx_now;
  logic              push_ok;
  state_t            after_pop, after_mask;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Start count saturates at the buffer length
  assign cnt_sat = (in_count > LEN_MAX) ? LEN_MAX : in_count;

  // Receive pops: bounded by bytes left, by bytes waiting and by the budget
  assign rx_min    = (rx_remaining < LEN_W'(in_rx_level)) ? rx_remaining
                                                          : LEN_W'(in_rx_level);
  assign pops_calc = (in_rx_full && reading)
                     ? ((rx_min > LEN_BUD) ? BUD_FULL : BUD_W'(rx_min))
                     : '0;
  assign rx_now    = (in_rx_level > LVL_W'(pops_calc))
                     ? in_rx_level - LVL_W'(pops_calc) : '0;

  // Room for one more command in this pass
  assign push_ok = (tx_remaining != '0) && (tx_room != '0) && (rx_room != '0)
                   && (budget != '0) && !(reading && (rx_outstanding >= DEPTH_R));

  always_comb begin
    if (tx_empty_q) begin
      after_pop = (total_len == '0) ? S_QUICK : S_PUSH;
    end else if (stop_q && (rx_outstanding == '0)) begin
      after_pop = S_FIN;
    end else begin
      after_pop = S_IDLE;
    end
    after_mask = (stop_q && (rx_outstanding == '0)) ? S_FIN : S_IDLE;
  end

  always_comb begin
    state_next          = state;
    active_next         = active;
    reading_next        = reading;
    total_len_next      = total_len;
    tx_remaining_next   = tx_remaining;
    rx_remaining_next   = rx_remaining;
    rx_outstanding_next = rx_outstanding;
    tx_pointer_next     = tx_pointer;
    pops_left_next      = pops_left;
    tx_room_next        = tx_room;
    rx_room_next        = rx_room;
    budget_next         = budget;
    fin_status_next     = fin_status;
    tx_empty_q_next     = tx_empty_q;
    stop_q_next         = stop_q;

    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_kind   = i2c_fts_pkg::KIND_PUSH;
    emit_cmd    = '0;
    emit_target = '0;
    emit_mask   = '0;
    emit_rx     = '0;
    emit_status = '0;
    emit_count  = '0;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (s_tuser)
            i2c_fts_pkg::OP_START: begin
              active_next         = 1'b1;
              reading_next        = in_is_read;
              total_len_next      = cnt_sat;
              tx_remaining_next   = cnt_sat;
              rx_remaining_next   = cnt_sat;
              rx_outstanding_next = '0;
              tx_pointer_next     = '0;
              state_next          = S_SETUP;
            end
            i2c_fts_pkg::OP_RXBYTE: begin
              state_next = S_RXB;
            end
            i2c_fts_pkg::OP_STATUS: begin
              if (active) begin
                tx_empty_q_next = in_tx_empty;
                stop_q_next     = in_stop;
                if (in_timeout) begin
                  fin_status_next = i2c_fts_pkg::ST_TIMEOUT;
                  state_next      = S_FIN;
                end else if (in_abort) begin
                  fin_status_next     = i2c_fts_pkg::ST_ABORT;
                  rx_outstanding_next = '0;
                  state_next          = S_AMASK;
                end else begin
                  fin_status_next     = i2c_fts_pkg::ST_OK;
                  pops_left_next      = pops_calc;
                  rx_remaining_next   = rx_remaining - LEN_W'(pops_calc);
                  rx_outstanding_next = (rx_outstanding > ROOM_W'(pops_calc))
                                        ? rx_outstanding - ROOM_W'(pops_calc) : '0;
                  tx_room_next  = (ROOM_W'(in_tx_level) < DEPTH_R)
                                  ? DEPTH_R - ROOM_W'(in_tx_level) : '0;
                  rx_room_next  = (ROOM_W'(rx_now) < DEPTH_R)
                                  ? DEPTH_R - ROOM_W'(rx_now) : '0;
                  budget_next   = BUD_FULL - pops_calc;
                  state_next    = S_POP;
                end
              end
            end
            default: begin
              // Load: the buffer write happens in the RAM block
            end
          endcase
        end
      end
      S_SETUP: begin
        emit_kind   = i2c_fts_pkg::KIND_SETUP;
        emit_target = target_q;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_SMASK;
        end
      end
      S_SMASK: begin
        emit_kind = i2c_fts_pkg::KIND_MASK;
        emit_mask = i2c_fts_pkg::MASK_ALL;
        emit_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RXB: begin
        emit_kind = i2c_fts_pkg::KIND_RXBYTE;
        emit_rx   = rx_byte_q;
        emit_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_AMASK: begin
        emit_kind = i2c_fts_pkg::KIND_MASK;
        emit_mask = i2c_fts_pkg::MASK_NONE;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_FIN;
        end
      end
      S_POP: begin
        emit_kind = i2c_fts_pkg::KIND_POP;
        emit_last = (pops_left == BUD_W'(1)) && (after_pop == S_IDLE);
        if (pops_left == '0) begin
          state_next = after_pop;
        end else if (out_free) begin
          emit           = 1'b1;
          pops_left_next = pops_left - BUD_W'(1);
          if (pops_left == BUD_W'(1)) begin
            state_next = after_pop;
          end
        end
      end
      S_QUICK: begin
        emit_kind = i2c_fts_pkg::KIND_PUSH;
        emit_cmd  = i2c_fts_pkg::CMD_STOP | (reading ? i2c_fts_pkg::CMD_READ : '0);
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        emit_kind = i2c_fts_pkg::KIND_PUSH;
        emit_cmd  = ((tx_remaining == LEN_W'(1)) ? i2c_fts_pkg::CMD_STOP : '0)
                    | (reading ? i2c_fts_pkg::CMD_READ : {2'b00, buf_rd});
        if (!push_ok) begin
          state_next = S_MASK;
        end else if (out_free) begin
          emit              = 1'b1;
          tx_room_next      = tx_room - ROOM_W'(1);
          tx_remaining_next = tx_remaining - LEN_W'(1);
          budget_next       = budget - BUD_W'(1);
          if (reading) begin
            rx_room_next        = rx_room - ROOM_W'(1);
            rx_outstanding_next = rx_outstanding + ROOM_W'(1);
          end else begin
            tx_pointer_next = tx_pointer + PTR_W'(1);
          end
        end
      end
      S_MASK: begin
        emit_kind = i2c_fts_pkg::KIND_MASK;
        emit_mask = (tx_remaining == '0)
                    ? (i2c_fts_pkg::MASK_ALL & ~i2c_fts_pkg::MASK_TXE)
                    : i2c_fts_pkg::MASK_ALL;
        emit_last = (after_mask == S_IDLE);
        if (out_free) begin
          emit       = 1'b1;
          state_next = after_mask;
        end
      end
      S_FIN: begin
        emit_kind   = i2c_fts_pkg::KIND_FINISH;
        emit_status = fin_status;
        emit_count  = total_len - (reading ? rx_remaining : tx_remaining);
        emit_last   = 1'b1;
        if (out_free) begin
          emit        = 1'b1;
          active_next = 1'b0;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active         <= 1'b0;
      reading        <= 1'b0;
      total_len      <= '0;
      tx_remaining   <= '0;
      rx_remaining   <= '0;
      rx_outstanding <= '0;
      tx_pointer     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      active         <= active_next;
      reading        <= reading_next;
      total_len      <= total_len_next;
      tx_remaining   <= tx_remaining_next;
      rx_remaining   <= rx_remaining_next;
      rx_outstanding <= rx_outstanding_next;
      tx_pointer     <= tx_pointer_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Work registers and output payload
  always_ff @(posedge clk) begin
    pops_left  <= pops_left_next;
    tx_room    <= tx_room_next;
    rx_room    <= rx_room_next;
    budget     <= budget_next;
    fin_status <= fin_status_next;
    tx_empty_q <= tx_empty_q_next;
    stop_q     <= stop_q_next;
    if (in_accept) begin
      target_q  <= {10'd0, in_addr}
                   | ((cnt_sat == '0) ? (i2c_fts_pkg::TGT_QUICK | i2c_fts_pkg::TGT_SPECIAL)
                                      : '0);
      rx_byte_q <= in_byte;
    end
    if (emit) begin
      out_kind   <= emit_kind;
      out_cmd    <= emit_cmd;
      out_target <= emit_target;
      out_mask   <= emit_mask;
      out_rx     <= emit_rx;
      out_status <= emit_status;
      out_count  <= emit_count;
      m_tlast    <= emit_last;
    end
  end

  // Transmit buffer: write on load, re-read at the next pointer every cycle
  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == i2c_fts_pkg::OP_LOAD)) begin
      tx_buffer[in_count[PTR_W-1:0]] <= in_byte;
    end
    buf_rd <= tx_buffer[tx_pointer_next];
  end

  assign m_tuser = out_kind;
  assign m_tdata = {5'd0, out_count, out_status, out_rx, out_mask, out_target, out_cmd};

endmodule
